>>> rtl/gpio_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// gpio_pkg
// Shared types, register codes and pin masks of the GPIO port register block.
// ============================================================================
package gpio_pkg;

    // Number of implemented pins, from 1 to 16.
    localparam int PIN_COUNT = 16;

    // Alternate-function pins held in the low and high select words.
    localparam int ALT_LOW_PINS  = (PIN_COUNT > 8) ? 8 : PIN_COUNT;
    localparam int ALT_HIGH_PINS = (PIN_COUNT > 8) ? PIN_COUNT - 8 : 0;

    // Masks of the bits that belong to implemented pins.
    localparam logic [15:0] PIN_MASK1 = 16'((64'd1 << PIN_COUNT) - 64'd1);
    localparam logic [31:0] PIN_MASK2 = 32'((64'd1 << (2 * PIN_COUNT)) - 64'd1);
    localparam logic [31:0] ALT_LOW_MASK  = 32'((64'd1 << (4 * ALT_LOW_PINS)) - 64'd1);
    localparam logic [31:0] ALT_HIGH_MASK = 32'((64'd1 << (4 * ALT_HIGH_PINS)) - 64'd1);

    typedef enum logic [1:0] {
        ACT_IDLE  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        REG_MODE     = 4'd0,
        REG_TYPE     = 4'd1,
        REG_SPEED    = 4'd2,
        REG_PULL     = 4'd3,
        REG_INPUT    = 4'd4,
        REG_OUTPUT   = 4'd5,
        REG_SETRESET = 4'd6,
        REG_LOCK     = 4'd7,
        REG_ALTLOW   = 4'd8,
        REG_ALTHIGH  = 4'd9
    } reg_index_t;

    // Two-bit field codes.
    localparam logic [1:0] FIELD_01 = 2'b01;
    localparam logic [1:0] FIELD_10 = 2'b10;
    localparam logic [1:0] FIELD_11 = 2'b11;

    // One bit per pin whose two-bit field in the word equals the code.
    function automatic logic [15:0] pins_with(input logic [31:0] word,
                                              input logic [1:0] code);
        logic [15:0] m;
        m = '0;
        for (int n = 0; n < 16; n++) begin
            m[n] = (word[2*n +: 2] == code);
        end
        return m & PIN_MASK1;
    endfunction

endpackage

>>> rtl/gpio_port_register_block.sv
`timescale 1ns / 1ps
// ============================================================================
// gpio_port_register_block
// Register file and pin control decode of a 16-pin general purpose I/O port.
// ============================================================================
// Each request on the input channel carries one bus access (idle, read or
// write), a register index, the write data and the sampled pad levels. For
// every request exactly one result appears on the output channel: the read
// word (zero unless the request was a read) and the full set of pin control
// signals, formed from the register state after the request's own write.
//
// The request is first captured in an input register, where the access is
// decoded. As it moves on, the configuration registers are updated and
// the result is written into the output register, where it waits to be
// taken. One request is accepted every cycle while the output side
// keeps taking results; the single input stage and the output register
// decouple the two channels.
//
// When the receiver stalls, the result holds in the output register and the
// captured request waits in the input register; in_stall rises only when
// both are occupied. Reset clears every configuration register to zero (all
// pins inputs, push-pull, no pulls, outputs low) and empties both stages.
// ============================================================================
module gpio_port_register_block
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [3:0]  reg_index,
    input  logic [31:0] write_data,
    input  logic [15:0] pad_levels,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic [15:0] drive_levels,
    output logic [15:0] output_enable,
    output logic [15:0] alt_function_mask,
    output logic [15:0] analog_mask,
    output logic [15:0] open_drain,
    output logic [15:0] pull_up,
    output logic [15:0] pull_down,
    output logic [31:0] speed_bits,
    output logic [31:0] alt_select_low,
    output logic [31:0] alt_select_high
);

    // Input stage.
    logic        s1_valid_reg;
    logic [1:0]  act_reg;
    logic [3:0]  idx_reg;
    logic [31:0] wdata_reg;
    logic [15:0] pads_reg;

    // Configuration registers.
    logic [31:0] mode_reg,     mode_next;
    logic [15:0] type_reg,     type_next;
    logic [31:0] speed_reg,    speed_next;
    logic [31:0] pull_reg,     pull_next;
    logic [15:0] output_reg,   output_next;
    logic [31:0] alt_low_reg,  alt_low_next;
    logic [31:0] alt_high_reg, alt_high_next;

    // Output stage.
    logic        out_valid_reg;
    logic [31:0] rdata_reg, rdata_next;
    logic [15:0] drive_reg;
    logic [15:0] oe_reg;
    logic [15:0] af_reg;
    logic [15:0] an_reg;
    logic [15:0] od_reg;
    logic [15:0] pu_reg;
    logic [15:0] pd_reg;
    logic [31:0] spd_reg;
    logic [31:0] asl_reg;
    logic [31:0] ash_reg;

    logic        in_accept;
    logic        s1_take;
    logic [15:0] set_bits;
    logic [15:0] clr_bits;

    // The captured request moves on when the output register is free or
    // its result is being taken in this cycle.
    assign s1_take   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_take;
    assign in_accept = in_valid && !in_stall;

    assign set_bits = wdata_reg[15:0];
    assign clr_bits = wdata_reg[31:16];

    // Register update and read selection for the request in the input stage.
    always_comb
    begin
        mode_next     = mode_reg;
        type_next     = type_reg;
        speed_next    = speed_reg;
        pull_next     = pull_reg;
        output_next   = output_reg;
        alt_low_next  = alt_low_reg;
        alt_high_next = alt_high_reg;
        rdata_next    = '0;

        if (act_reg == gpio_pkg::ACT_READ)
        begin
            case (idx_reg)
                gpio_pkg::REG_MODE:    rdata_next = mode_reg;
                gpio_pkg::REG_TYPE:    rdata_next = {16'd0, type_reg};
                gpio_pkg::REG_SPEED:   rdata_next = speed_reg;
                gpio_pkg::REG_PULL:    rdata_next = pull_reg;
                // The input word always shows the pads of this same request.
                gpio_pkg::REG_INPUT:   rdata_next = {16'd0, pads_reg & gpio_pkg::PIN_MASK1};
                gpio_pkg::REG_OUTPUT:  rdata_next = {16'd0, output_reg};
                gpio_pkg::REG_ALTLOW:  rdata_next = alt_low_reg;
                gpio_pkg::REG_ALTHIGH: rdata_next = alt_high_reg;
                default:               rdata_next = '0;
            endcase
        end
        else if (act_reg == gpio_pkg::ACT_WRITE)
        begin
            case (idx_reg)
                gpio_pkg::REG_MODE:    mode_next   = wdata_reg & gpio_pkg::PIN_MASK2;
                gpio_pkg::REG_TYPE:    type_next   = wdata_reg[15:0] & gpio_pkg::PIN_MASK1;
                gpio_pkg::REG_SPEED:   speed_next  = wdata_reg & gpio_pkg::PIN_MASK2;
                gpio_pkg::REG_PULL:    pull_next   = wdata_reg & gpio_pkg::PIN_MASK2;
                gpio_pkg::REG_OUTPUT:  output_next = wdata_reg[15:0] & gpio_pkg::PIN_MASK1;
                // Set takes priority over clear for the same bit.
                gpio_pkg::REG_SETRESET:
                    output_next = ((output_reg & ~clr_bits) | set_bits)
                                  & gpio_pkg::PIN_MASK1;
                gpio_pkg::REG_ALTLOW:  alt_low_next  = wdata_reg & gpio_pkg::ALT_LOW_MASK;
                gpio_pkg::REG_ALTHIGH: alt_high_next = wdata_reg & gpio_pkg::ALT_HIGH_MASK;
                default:               ;
            endcase
        end
    end

    // Control state of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_take)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers change only as a request leaves the input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= '0;
            type_reg     <= '0;
            speed_reg    <= '0;
            pull_reg     <= '0;
            output_reg   <= '0;
            alt_low_reg  <= '0;
            alt_high_reg <= '0;
        end
        else if (s1_take)
        begin
            mode_reg     <= mode_next;
            type_reg     <= type_next;
            speed_reg    <= speed_next;
            pull_reg     <= pull_next;
            output_reg   <= output_next;
            alt_low_reg  <= alt_low_next;
            alt_high_reg <= alt_high_next;
        end
    end

    // Request payload capture.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg   <= action;
            idx_reg   <= reg_index;
            wdata_reg <= write_data;
            pads_reg  <= pad_levels;
        end
    end

    // Result payload, formed from the updated register state.
    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            rdata_reg <= rdata_next;
            drive_reg <= output_next;
            oe_reg    <= gpio_pkg::pins_with(mode_next, gpio_pkg::FIELD_01);
            af_reg    <= gpio_pkg::pins_with(mode_next, gpio_pkg::FIELD_10);
            an_reg    <= gpio_pkg::pins_with(mode_next, gpio_pkg::FIELD_11);
            od_reg    <= type_next;
            pu_reg    <= gpio_pkg::pins_with(pull_next, gpio_pkg::FIELD_01);
            pd_reg    <= gpio_pkg::pins_with(pull_next, gpio_pkg::FIELD_10);
            spd_reg   <= speed_next;
            asl_reg   <= alt_low_next;
            ash_reg   <= alt_high_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign read_data         = rdata_reg;
    assign drive_levels      = drive_reg;
    assign output_enable     = oe_reg;
    assign alt_function_mask = af_reg;
    assign analog_mask       = an_reg;
    assign open_drain        = od_reg;
    assign pull_up           = pu_reg;
    assign pull_down         = pd_reg;
    assign speed_bits        = spd_reg;
    assign alt_select_low    = asl_reg;
    assign alt_select_high   = ash_reg;

endmodule

>>> tb/gpio_port_register_block_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// gpio_port_register_block_tb
// Self-checking bench for the GPIO port register block.
// ============================================================================
// A scoreboard keeps its own copy of the port registers. It works out the
// read word and the pin control signals that each accepted request should
// produce, and checks every result that the block hands back against the
// oldest outstanding expectation. A short directed run covers the register
// extremes and the corner cases of the register map. About 1600 random
// requests follow, with random idling on both channels, a long hold-off on
// the result side and one pause until the block has drained.
// ============================================================================
module gpio_port_register_block_tb;

    // Action code that the package leaves unnamed; the block treats it as idle.
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    // Register indexes beyond the implemented map.
    localparam logic [3:0] INDEX_FIRST_UNUSED = 4'd10;
    localparam logic [3:0] INDEX_LAST         = 4'd15;

    localparam int RANDOM_REQUESTS = 1600;
    localparam int HOLD_OFF_AT     = 400;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int PAUSE_AT        = 900;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200000;

    // One result as it leaves the block.
    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] drive_levels;
        logic [15:0] output_enable;
        logic [15:0] alt_function_mask;
        logic [15:0] analog_mask;
        logic [15:0] open_drain;
        logic [15:0] pull_up;
        logic [15:0] pull_down;
        logic [31:0] speed_bits;
        logic [31:0] alt_select_low;
        logic [31:0] alt_select_high;
    } pin_result_t;

    // Shadow of the port registers and the queue of results still to come.
    class pin_control_scoreboard;
        logic [31:0] mode_word     = '0;
        logic [15:0] type_word     = '0;
        logic [31:0] speed_word    = '0;
        logic [31:0] pull_word     = '0;
        logic [15:0] output_word   = '0;
        logic [15:0] input_word    = '0;
        logic [31:0] alt_low_word  = '0;
        logic [31:0] alt_high_word = '0;
        pin_result_t pending_pin_results[$];
        int errors  = 0;
        int reads   = 0;
        int writes  = 0;
        int checked = 0;

        // Applies one accepted request to the shadow registers and queues the
        // result that it should produce.
        function void note_request(logic [1:0] act, logic [3:0] idx,
                                   logic [31:0] wd, logic [15:0] pads);
            pin_result_t r;
            logic [15:0] set_bits;
            logic [15:0] clear_bits;
            r = '0;
            input_word = pads & gpio_pkg::PIN_MASK1;
            if (act == gpio_pkg::ACT_READ) begin
                reads++;
                case (idx)
                    gpio_pkg::REG_MODE:    r.read_data = mode_word;
                    gpio_pkg::REG_TYPE:    r.read_data = {16'h0000, type_word};
                    gpio_pkg::REG_SPEED:   r.read_data = speed_word;
                    gpio_pkg::REG_PULL:    r.read_data = pull_word;
                    gpio_pkg::REG_INPUT:   r.read_data = {16'h0000, input_word};
                    gpio_pkg::REG_OUTPUT:  r.read_data = {16'h0000, output_word};
                    gpio_pkg::REG_ALTLOW:  r.read_data = alt_low_word;
                    gpio_pkg::REG_ALTHIGH: r.read_data = alt_high_word;
                    default:               r.read_data = '0;
                endcase
            end else if (act == gpio_pkg::ACT_WRITE) begin
                writes++;
                case (idx)
                    gpio_pkg::REG_MODE:    mode_word = wd & gpio_pkg::PIN_MASK2;
                    gpio_pkg::REG_TYPE:    type_word = wd[15:0] & gpio_pkg::PIN_MASK1;
                    gpio_pkg::REG_SPEED:   speed_word = wd & gpio_pkg::PIN_MASK2;
                    gpio_pkg::REG_PULL:    pull_word = wd & gpio_pkg::PIN_MASK2;
                    gpio_pkg::REG_OUTPUT:  output_word = wd[15:0] & gpio_pkg::PIN_MASK1;
                    gpio_pkg::REG_SETRESET:
                    begin
                        set_bits    = wd[15:0];
                        clear_bits  = wd[31:16];
                        output_word = ((output_word & ~clear_bits) | set_bits)
                                      & gpio_pkg::PIN_MASK1;
                    end
                    gpio_pkg::REG_ALTLOW:  alt_low_word = wd & gpio_pkg::ALT_LOW_MASK;
                    gpio_pkg::REG_ALTHIGH: alt_high_word = wd & gpio_pkg::ALT_HIGH_MASK;
                    default:               ;
                endcase
            end
            for (int n = 0; n < 16; n++)
            begin
                r.output_enable[n]     = (mode_word[2*n +: 2] == gpio_pkg::FIELD_01);
                r.alt_function_mask[n] = (mode_word[2*n +: 2] == gpio_pkg::FIELD_10);
                r.analog_mask[n]       = (mode_word[2*n +: 2] == gpio_pkg::FIELD_11);
                r.pull_up[n]           = (pull_word[2*n +: 2] == gpio_pkg::FIELD_01);
                r.pull_down[n]         = (pull_word[2*n +: 2] == gpio_pkg::FIELD_10);
            end
            r.output_enable     &= gpio_pkg::PIN_MASK1;
            r.alt_function_mask &= gpio_pkg::PIN_MASK1;
            r.analog_mask       &= gpio_pkg::PIN_MASK1;
            r.pull_up           &= gpio_pkg::PIN_MASK1;
            r.pull_down         &= gpio_pkg::PIN_MASK1;
            r.drive_levels      = output_word;
            r.open_drain        = type_word;
            r.speed_bits        = speed_word;
            r.alt_select_low    = alt_low_word;
            r.alt_select_high   = alt_high_word;
            pending_pin_results.push_back(r);
        endfunction

        function int pending();
            return pending_pin_results.size();
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
            end
        endfunction

        // Checks one result from the block against the oldest expectation.
        function void check_result(pin_result_t got);
            pin_result_t want;
            if (pending_pin_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request outstanding, read_data %h",
                         $time, got.read_data);
                return;
            end
            want = pending_pin_results.pop_front();
            checked++;
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("drive_levels", 32'(want.drive_levels), 32'(got.drive_levels));
            compare_field("output_enable", 32'(want.output_enable),
                          32'(got.output_enable));
            compare_field("alt_function_mask", 32'(want.alt_function_mask),
                          32'(got.alt_function_mask));
            compare_field("analog_mask", 32'(want.analog_mask), 32'(got.analog_mask));
            compare_field("open_drain", 32'(want.open_drain), 32'(got.open_drain));
            compare_field("pull_up", 32'(want.pull_up), 32'(got.pull_up));
            compare_field("pull_down", 32'(want.pull_down), 32'(got.pull_down));
            compare_field("speed_bits", want.speed_bits, got.speed_bits);
            compare_field("alt_select_low", want.alt_select_low, got.alt_select_low);
            compare_field("alt_select_high", want.alt_select_high, got.alt_select_high);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [15:0] pad_levels;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] read_data;
    logic [15:0] drive_levels;
    logic [15:0] output_enable;
    logic [15:0] alt_function_mask;
    logic [15:0] analog_mask;
    logic [15:0] open_drain;
    logic [15:0] pull_up;
    logic [15:0] pull_down;
    logic [31:0] speed_bits;
    logic [31:0] alt_select_low;
    logic [31:0] alt_select_high;

    pin_control_scoreboard scoreboard;

    // While set, neither side idles at random, so the block runs at full rate.
    bit burst_mode = 1'b0;
    int requests_sent = 0;
    int results_taken = 0;
    int cycle_count = 0;

    gpio_port_register_block DUT
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .reg_index         (reg_index),
        .write_data        (write_data),
        .pad_levels        (pad_levels),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .read_data         (read_data),
        .drive_levels      (drive_levels),
        .output_enable     (output_enable),
        .alt_function_mask (alt_function_mask),
        .analog_mask       (analog_mask),
        .open_drain        (open_drain),
        .pull_up           (pull_up),
        .pull_down         (pull_down),
        .speed_bits        (speed_bits),
        .alt_select_low    (alt_select_low),
        .alt_select_high   (alt_select_high)
    );

    always #10 clk = ~clk;

    // Watchdog: a hung handshake ends the run here rather than running forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, scoreboard.pending());
            $display("[gpio_port_register_block] ERROR");
            $finish;
        end
    end

    // Offers one request after a random idle gap and holds it until the block
    // takes it. With a zero gap the valid simply stays high, so it is never
    // lowered and raised again within the same time step.
    task automatic send_request(input logic [1:0] act, input logic [3:0] idx,
                                input logic [31:0] wd, input logic [15:0] pads);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        reg_index  <= idx;
        write_data <= wd;
        pad_levels <= pads;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        scoreboard.note_request(act, idx, wd, pads);
        requests_sent++;
    endtask

    // Mostly reads and writes to the implemented map, with some idle and
    // reserved actions and some accesses to indexes beyond the map. Data and
    // pad words lean towards all-zero and all-one now and then.
    task automatic send_random_request();
        logic [1:0]  act;
        logic [3:0]  idx;
        logic [31:0] wd;
        logic [15:0] pads;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            act = gpio_pkg::ACT_WRITE;
        else if (pick < 8)
            act = gpio_pkg::ACT_READ;
        else if (pick == 8)
            act = gpio_pkg::ACT_IDLE;
        else
            act = ACT_RESERVED;
        if ($urandom_range(0, 7) == 0)
            idx = 4'($urandom_range(INDEX_FIRST_UNUSED, INDEX_LAST));
        else
            idx = 4'($urandom_range(gpio_pkg::REG_MODE, gpio_pkg::REG_ALTHIGH));
        case ($urandom_range(0, 7))
            0:       wd = '0;
            1:       wd = '1;
            default: wd = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0:       pads = '0;
            1:       pads = '1;
            default: pads = 16'($urandom);
        endcase
        send_request(act, idx, wd, pads);
    endtask

    // Result side. Before each result it stalls for a random number of cycles,
    // whether or not a result is already waiting, so the stall lands on every
    // phase of the pipeline. Once in the run it holds off long enough for
    // both internal stages to fill and the block to stall its requests.
    initial
    begin
        int stall_len;
        pin_result_t got;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (results_taken == HOLD_OFF_AT)
                stall_len = HOLD_OFF_CYCLES;
            else
                stall_len = burst_mode ? 0 : $urandom_range(0, 4);
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got.read_data         = read_data;
            got.drive_levels      = drive_levels;
            got.output_enable     = output_enable;
            got.alt_function_mask = alt_function_mask;
            got.analog_mask       = analog_mask;
            got.open_drain        = open_drain;
            got.pull_up           = pull_up;
            got.pull_down         = pull_down;
            got.speed_bits        = speed_bits;
            got.alt_select_low    = alt_select_low;
            got.alt_select_high   = alt_select_high;
            scoreboard.check_result(got);
            results_taken++;
        end
    end

    // Request side and end of run.
    initial
    begin
        scoreboard = new;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = gpio_pkg::ACT_IDLE;
        reg_index  = gpio_pkg::REG_MODE;
        write_data = '0;
        pad_levels = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset value, then every two-bit mode code across the pins.
        send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_MODE, 32'h0000_0000, 16'h0000);
        send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_MODE, 32'hE4E4_E4E4, 16'hFFFF);
        send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_MODE, 32'hFFFF_FFFF, 16'h0000);
        // Upper half of the type word must be dropped.
        send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_TYPE, 32'hFFFF_FFFF, 16'h5A5A);
        send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_TYPE, 32'h0000_0000, 16'hFFFF);
        send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_SPEED, 32'hFFFF_FFFF, 16'h0000);
        // Every pull code, the reserved one among them, which shows no pull.
        send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_PULL, 32'hE4E4_E4E4, 16'h0000);
        send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_PULL, 32'h0000_0000, 16'h0000);
        // The input word ignores writes and follows the pads of each request.
        send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_INPUT, 32'hFFFF_FFFF, 16'h0000);
        send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_INPUT, 32'h0000_0000, 16'hA5A5);
        send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_INPUT, 32'h0000_0000, 16'hFFFF);
        send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_OUTPUT, 32'hFFFF_FFFF, 16'h0000);
        // Clear everything, then name the low byte in both halves: set wins.
        send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_SETRESET, 32'hFFFF_0000, 16'h0000);
        send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_SETRESET, 32'hFFFF_00FF, 16'h0000);
        send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_OUTPUT, 32'h0000_0000, 16'h0000);
        send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_SETRESET, 32'h0000_0000, 16'h0000);
        // The lock word ignores writes and reads as zero.
        send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_LOCK, 32'hFFFF_FFFF, 16'h0000);
        send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_LOCK, 32'h0000_0000, 16'h0000);
        send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_ALTLOW, 32'hFFFF_FFFF, 16'h0000);
        send_request(gpio_pkg::ACT_WRITE, gpio_pkg::REG_ALTHIGH, 32'hFFFF_FFFF, 16'h0000);
        send_request(gpio_pkg::ACT_READ, gpio_pkg::REG_ALTHIGH, 32'h0000_0000, 16'h0000);
        // The reserved action behaves as no access.
        send_request(ACT_RESERVED, gpio_pkg::REG_SPEED, 32'hFFFF_FFFF, 16'hFFFF);
        // Indexes beyond the map: writes vanish, reads return zero.
        send_request(gpio_pkg::ACT_WRITE, INDEX_LAST, 32'hFFFF_FFFF, 16'h0000);
        send_request(gpio_pkg::ACT_READ, INDEX_FIRST_UNUSED, 32'h0000_0000, 16'h0000);
        send_request(gpio_pkg::ACT_IDLE, gpio_pkg::REG_MODE, 32'hFFFF_FFFF, 16'hFFFF);

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            // Every fourth block of a hundred requests runs without idling.
            burst_mode = ((i / 100) % 4) == 3;
            if (i == PAUSE_AT)
            begin
                // Let the block drain completely before carrying on. At least
                // one edge passes so the valid is not raised in the same step.
                in_valid <= 1'b0;
                do @(posedge clk); while (scoreboard.pending() != 0);
            end
            send_random_request();
        end
        burst_mode = 1'b0;
        in_valid <= 1'b0;

        while (scoreboard.pending() != 0) @(posedge clk);
        // A few more cycles so that any surplus result would still show up.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d reads, %0d writes) and checked %0d results,",
                 requests_sent, scoreboard.reads, scoreboard.writes, scoreboard.checked);
        $display("covering the full register map, both idle sides and a long result hold-off.");
        if (scoreboard.errors == 0)
        begin
            $display("[gpio_port_register_block] OK");
        end
        else
        begin
            $display("%0d mismatches found.", scoreboard.errors);
            $display("[gpio_port_register_block] ERROR");
        end
        $finish;
    end

endmodule
